FILE: rtl/core/fwdp_pkg.sv
// ----------------------------------------------------------------------------
// fwdp_pkg
// Constants and types for the fixed-width decimal field parser.
// ----------------------------------------------------------------------------
package fwdp_pkg;

    localparam int MAX_DIGITS = 8;
    localparam int MANT_W     = 28;
    localparam int ACC_W      = MANT_W - 1;           // holds 10^MAX_DIGITS - 1
    localparam int CNT_W      = $clog2(MAX_DIGITS + 2);
    localparam int FRAC_W     = 4;
    localparam int CHAR_W     = 8;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    typedef struct packed {
        logic              past_lead;
        logic              negative;
        logic              point_seen;
        logic              illegal_seen;
        logic              all_nines;
        logic [CNT_W-1:0]  digit_count;
        logic [FRAC_W-1:0] frac_count;
        logic [ACC_W-1:0]  acc;
    } parse_state_t;

    localparam parse_state_t STATE_CLEAR = '{
        past_lead:    1'b0,
        negative:     1'b0,
        point_seen:   1'b0,
        illegal_seen: 1'b0,
        all_nines:    1'b1,
        digit_count:  '0,
        frac_count:   '0,
        acc:          '0
    };

endpackage

FILE: rtl/core/fixed_width_decimal_field_parser_top.sv
// ----------------------------------------------------------------------------
// fixed_width_decimal_field_parser_top
// Parses one fixed-width ASCII decimal field, one character per word.
// ----------------------------------------------------------------------------
// Each accepted input word carries one character; the parse state updates in
// the cycle it is accepted, and on the field's last character a result word
// (signed mantissa, fraction digit count, missing flag) is registered and
// shown on the next cycle. One character is taken per clock: the only work is
// a multiply by ten (shift-and-add) plus one digit add on the accumulator.
// While a result word waits for m_ready the input stalls; a new character is
// taken in the same cycle the waiting result leaves, so back-to-back words
// flow at one per clock as long as m_ready stays high. A bad field returns
// mantissa 0 and fraction_digits 0.
module fixed_width_decimal_field_parser_top
    import fwdp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [CHAR_W-1:0]        s_char_code,
    input  logic                     s_first_char,
    input  logic                     s_last_char,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [MANT_W-1:0] m_mantissa,
    output logic [FRAC_W-1:0]        m_fraction_digits,
    output logic                     m_missing_flag
);

    parse_state_t state_reg, state_next;
    parse_state_t base;
    parse_state_t upd;

    logic                     m_valid_reg;
    logic signed [MANT_W-1:0] mant_reg, mant_next;
    logic [FRAC_W-1:0]        frac_reg, frac_next;
    logic                     miss_reg, miss_next;

    logic                     accept;
    logic                     is_space, is_minus, is_plus, is_point, is_digit, is_nine;
    logic                     sign_pos;
    logic [3:0]               digit_val;
    logic [ACC_W-1:0]         acc_x10;
    logic                     bad;
    logic [MANT_W-1:0]        mag;

    assign s_ready = ~m_valid_reg | m_ready;
    assign accept  = s_valid & s_ready;

    assign is_space  = (s_char_code == CHAR_SPACE);
    assign is_minus  = (s_char_code == CHAR_MINUS);
    assign is_plus   = (s_char_code == CHAR_PLUS);
    assign is_point  = (s_char_code == CHAR_POINT);
    assign is_digit  = (s_char_code >= CHAR_ZERO) && (s_char_code <= CHAR_NINE);
    assign is_nine   = (s_char_code == CHAR_NINE);
    assign digit_val = 4'(s_char_code - CHAR_ZERO);

    always_comb begin
        base     = s_first_char ? STATE_CLEAR : state_reg;
        upd      = base;
        sign_pos = ~base.past_lead;
        acc_x10  = {base.acc[ACC_W-4:0], 3'b000} + {base.acc[ACC_W-2:0], 1'b0};

        if (!is_space) begin
            upd.past_lead = 1'b1;
            if (sign_pos && is_minus) begin
                upd.negative = 1'b1;
            end else if (sign_pos && is_plus) begin
                upd.negative = base.negative;
            end else if (is_point && !base.point_seen) begin
                upd.point_seen = 1'b1;
            end else if (!is_digit) begin
                upd.illegal_seen = 1'b1;
            end else begin
                upd.all_nines = base.all_nines & is_nine;
                if (base.digit_count >= CNT_W'(MAX_DIGITS)) begin
                    // overflow: stop accumulating, park count above the limit
                    upd.digit_count = CNT_W'(MAX_DIGITS + 1);
                end else begin
                    upd.digit_count = base.digit_count + 1'b1;
                    upd.acc         = acc_x10 + ACC_W'(digit_val);
                    if (base.point_seen) begin
                        upd.frac_count = base.frac_count + 1'b1;
                    end
                end
            end
        end

        bad = upd.illegal_seen || (upd.digit_count == '0) || upd.all_nines ||
              (upd.digit_count > CNT_W'(MAX_DIGITS));
        mag = {1'b0, upd.acc};

        if (bad) begin
            mant_next = '0;
            frac_next = '0;
            miss_next = 1'b1;
        end else begin
            mant_next = upd.negative ? -$signed(mag) : $signed(mag);
            frac_next = upd.frac_count;
            miss_next = 1'b0;
        end

        // a finished field leaves the state clear for the next one
        state_next = s_last_char ? STATE_CLEAR : upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= STATE_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
            end
            if (accept && s_last_char) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_last_char) begin
            mant_reg <= mant_next;
            frac_reg <= frac_next;
            miss_reg <= miss_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_mantissa        = mant_reg;
    assign m_fraction_digits = frac_reg;
    assign m_missing_flag    = miss_reg;

endmodule
